[rtl/assert_macros.svh]
// Assertion macros for the checker file of this block.
// Include with the bare file name; each macro takes a label, clock, reset and property terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed (same cycle)");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed (next cycle)");

`endif

[rtl/ssqa_pkg.sv]
// Shared codes and widths for the sensor sample quality aggregator.
// No dependencies; used by the core and its checker.
`timescale 1ns / 1ps
package ssqa_pkg;

    localparam int DATA_W   = 32;
    localparam int JUMP_W   = 31;
    localparam int MCAP_W   = 7;
    localparam int PCAP_W   = 5;
    localparam int KIND_W   = 2;
    localparam int QUAL_W   = 2;
    localparam int CFG_AW   = 3;
    localparam int TDATA_W  = 40;

    // validity ratio: ok * 1000 >= fill * 666
    localparam int VALID_NUM = 1000;
    localparam int VALID_DEN = 666;

    localparam logic [KIND_W-1:0] REQ_SAMPLE = 2'd0;
    localparam logic [KIND_W-1:0] REQ_CLOSE  = 2'd1;
    localparam logic [KIND_W-1:0] REQ_REPORT = 2'd2;

    localparam logic [QUAL_W-1:0] Q_OK       = 2'd0;
    localparam logic [QUAL_W-1:0] Q_LIMITS   = 2'd1;
    localparam logic [QUAL_W-1:0] Q_JUMP     = 2'd2;
    localparam logic [QUAL_W-1:0] Q_NOTVALID = 2'd3;

    localparam logic [CFG_AW-1:0] CFG_MIN_LIMIT   = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_MAX_LIMIT   = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_MINUTE_JUMP = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_PERIOD_JUMP = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_MINUTE_CAP  = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_PERIOD_CAP  = 3'd5;

endpackage

[rtl/sensor_sample_quality_aggregator_core.sv]
// Sensor sample quality aggregator: two-level quality control of Q16.16 readings.
// Depends on ssqa_pkg. One item is worked on at a time. A sample item drops the oldest
// entries of a full minute store, then pushes itself there. A close-minute item divides
// the minute sum, clears the minute store, drops entries from a full period store and
// pushes the average there. A report item divides the period sum and clears the period
// store. SW is the width of the wider running sum. The average comes from a bit-serial
// restoring divider that settles one quotient bit a cycle. The next item is taken as
// soon as the result is in the output register, even while that result still waits.
// A waiting result holds the following result back until the register is free.
// Minute and period stores are circular buffers; entries are read only after being
// written, so they need no clearing after reset. The newest OK value of each level is
// kept in a register and is valid whenever that level's OK count is non-zero.
`timescale 1ns / 1ps
module sensor_sample_quality_aggregator_core
    import ssqa_pkg::*;
#(
    parameter int MINUTE_SLOTS = 64,
    parameter int PERIOD_SLOTS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_AW-1:0]    i_cfg_addr,
    input  logic [DATA_W-1:0]    i_cfg_data,
    // input items
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [TDATA_W-1:0]   s_axis_tdata,  // [31:0] sample_value, [32] sample_missing
    input  logic [KIND_W-1:0]    s_axis_tuser,  // [1:0] req_type
    // result items
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [TDATA_W-1:0]   m_axis_tdata,  // [1:0] quality, [33:2] average
    output logic [KIND_W-1:0]    m_axis_tuser   // [1:0] result_kind
);

    localparam int MAW = (MINUTE_SLOTS > 1) ? $clog2(MINUTE_SLOTS) : 1;
    localparam int PAW = (PERIOD_SLOTS > 1) ? $clog2(PERIOD_SLOTS) : 1;
    localparam int MFW = $clog2(MINUTE_SLOTS + 1);
    localparam int PFW = $clog2(PERIOD_SLOTS + 1);
    localparam int FW  = (MFW > PFW) ? MFW : PFW;
    localparam int MSW = DATA_W + MAW;
    localparam int PSW = DATA_W + PAW;
    localparam int SW  = (MSW > PSW) ? MSW : PSW;
    localparam int DCW = $clog2(SW + 1);
    localparam int MCW = (MFW > MCAP_W) ? MFW : MCAP_W;
    localparam int PCW = (PFW > PCAP_W) ? PFW : PCAP_W;
    localparam int VW  = FW + 10;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_CLOSE, S_REPORT, S_DROP_RD, S_DROP, S_PUSH, S_DONE, S_SKIP
    } t_state;

    t_state r_state;

    // configuration
    logic signed [DATA_W-1:0] r_min_limit, r_max_limit;
    logic [JUMP_W-1:0]        r_mjump, r_pjump;
    logic [MCAP_W-1:0]        r_mcap;
    logic [PCAP_W-1:0]        r_pcap;

    // minute level
    logic [DATA_W:0]          r_mmem [MINUTE_SLOTS];  // {ok, value}
    logic [DATA_W:0]          r_mrd;
    logic [MAW-1:0]           r_mhead, r_mtail;
    logic [MFW-1:0]           r_mfill, r_mokc;
    logic signed [MSW-1:0]    r_msum;
    logic signed [DATA_W-1:0] r_mlast;

    // period level
    logic [DATA_W:0]          r_pmem [PERIOD_SLOTS];
    logic [DATA_W:0]          r_prd;
    logic [PAW-1:0]           r_phead, r_ptail;
    logic [PFW-1:0]           r_pfill, r_pokc;
    logic signed [PSW-1:0]    r_psum;
    logic signed [DATA_W-1:0] r_plast;

    // item in flight
    logic [KIND_W-1:0]        r_kind;
    logic [QUAL_W-1:0]        r_q;
    logic signed [DATA_W-1:0] r_v;
    logic                     r_lvl;  // 0 minute, 1 period

    // bit-serial divider
    logic [SW-1:0]            r_dq;
    logic [FW-1:0]            r_drem, r_ddiv;
    logic [DCW-1:0]           r_dcnt;
    logic                     r_dsign;

    // output register
    logic                     r_out_valid;
    logic [KIND_W-1:0]        r_out_kind;
    logic [QUAL_W-1:0]        r_out_q;
    logic signed [DATA_W-1:0] r_out_avg;

    function automatic logic jump_ok(input logic signed [DATA_W-1:0] a,
                                     input logic signed [DATA_W-1:0] b,
                                     input logic [JUMP_W-1:0] lim);
        logic signed [DATA_W:0] d;
        logic [DATA_W:0]        m;
        d = (DATA_W+1)'(a) - (DATA_W+1)'(b);
        m = d[DATA_W] ? (DATA_W+1)'(-d) : (DATA_W+1)'(d);
        return m <= {2'b00, lim};
    endfunction

    function automatic logic store_valid(input logic [FW-1:0] fill, input logic [FW-1:0] okc);
        logic [VW-1:0] a, b;
        a = VW'(okc) * VW'(VALID_NUM);
        b = VW'(fill) * VW'(VALID_DEN);
        return (fill != '0) && (a >= b);
    endfunction

    // input decode and sample quality
    logic [KIND_W-1:0]        w_in_kind;
    logic                     w_missing;
    logic signed [DATA_W-1:0] w_sv;
    logic [QUAL_W-1:0]        w_sample_q;

    assign w_in_kind = s_axis_tuser;
    assign w_missing = s_axis_tdata[DATA_W];
    assign w_sv      = w_missing ? '0 : $signed(s_axis_tdata[DATA_W-1:0]);

    always_comb begin
        if (w_missing || (w_sv < r_min_limit) || (w_sv > r_max_limit)) begin
            w_sample_q = Q_LIMITS;
        end else if ((r_mokc != '0) && !jump_ok(r_mlast, w_sv, r_mjump)) begin
            w_sample_q = Q_JUMP;
        end else begin
            w_sample_q = Q_OK;
        end
    end

    // effective capacities: 0 acts as 1, above slot count acts as slot count
    logic [MCW-1:0] w_mcap_x;
    logic [PCW-1:0] w_pcap_x;
    logic [FW-1:0]  w_mcap, w_pcap, w_cur_cap, w_cur_fill;

    assign w_mcap_x = MCW'(r_mcap);
    assign w_pcap_x = PCW'(r_pcap);
    assign w_mcap = (w_mcap_x == '0) ? FW'(1) :
                    (w_mcap_x > MCW'(MINUTE_SLOTS)) ? FW'(MINUTE_SLOTS) : FW'(w_mcap_x);
    assign w_pcap = (w_pcap_x == '0) ? FW'(1) :
                    (w_pcap_x > PCW'(PERIOD_SLOTS)) ? FW'(PERIOD_SLOTS) : FW'(w_pcap_x);
    assign w_cur_cap  = r_lvl ? w_pcap : w_mcap;
    assign w_cur_fill = r_lvl ? FW'(r_pfill) : FW'(r_mfill);

    // divider operands and step
    logic signed [SW-1:0]     w_div_src;
    logic [SW-1:0]            w_div_abs;
    logic [FW-1:0]            w_div_cnt;
    logic [FW:0]              w_shift;
    logic                     w_qbit;
    logic [DATA_W-1:0]        w_qlo;
    logic signed [DATA_W-1:0] w_div_avg;
    logic                     w_close_jump_ok;

    assign w_div_src = (w_in_kind == REQ_CLOSE) ? SW'(r_msum) : SW'(r_psum);
    assign w_div_abs = w_div_src[SW-1] ? SW'(-w_div_src) : SW'(w_div_src);
    assign w_div_cnt = (w_in_kind == REQ_CLOSE) ? FW'(r_mokc) : FW'(r_pokc);
    assign w_shift   = {r_drem, r_dq[SW-1]};
    assign w_qbit    = (w_shift >= {1'b0, r_ddiv});
    assign w_qlo     = r_dq[DATA_W-1:0];
    assign w_div_avg = (r_ddiv == '0) ? '0 : (r_dsign ? $signed(-w_qlo) : $signed(w_qlo));
    assign w_close_jump_ok = (r_pokc == '0) || jump_ok(r_plast, w_div_avg, r_pjump);

    // store writes
    logic w_mwe, w_pwe;
    assign w_mwe = (r_state == S_PUSH) && !r_lvl;
    assign w_pwe = (r_state == S_PUSH) && r_lvl;

    always_ff @(posedge i_clk) begin
        if (w_mwe) begin
            r_mmem[r_mtail] <= {(r_q == Q_OK), r_v};
        end
        r_mrd <= r_mmem[r_mhead];
    end

    always_ff @(posedge i_clk) begin
        if (w_pwe) begin
            r_pmem[r_ptail] <= {(r_q == Q_OK), r_v};
        end
        r_prd <= r_pmem[r_phead];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_min_limit <= {1'b1, {(DATA_W-1){1'b0}}};
            r_max_limit <= {1'b0, {(DATA_W-1){1'b1}}};
            r_mjump     <= '1;
            r_pjump     <= '1;
            r_mcap      <= MCAP_W'(64);
            r_pcap      <= PCAP_W'(16);
            r_mhead     <= '0;
            r_mtail     <= '0;
            r_mfill     <= '0;
            r_mokc      <= '0;
            r_msum      <= '0;
            r_phead     <= '0;
            r_ptail     <= '0;
            r_pfill     <= '0;
            r_pokc      <= '0;
            r_psum      <= '0;
            r_lvl       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_MIN_LIMIT:   r_min_limit <= $signed(i_cfg_data);
                    CFG_MAX_LIMIT:   r_max_limit <= $signed(i_cfg_data);
                    CFG_MINUTE_JUMP: r_mjump     <= i_cfg_data[JUMP_W-1:0];
                    CFG_PERIOD_JUMP: r_pjump     <= i_cfg_data[JUMP_W-1:0];
                    CFG_MINUTE_CAP:  r_mcap      <= i_cfg_data[MCAP_W-1:0];
                    CFG_PERIOD_CAP:  r_pcap      <= i_cfg_data[PCAP_W-1:0];
                    default: ;
                endcase
            end

            // drop the result once taken; in S_DONE the load below decides
            if (r_out_valid && m_axis_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_kind <= w_in_kind;
                        case (w_in_kind)
                            REQ_SAMPLE: begin
                                r_v     <= w_sv;
                                r_q     <= w_sample_q;
                                r_lvl   <= 1'b0;
                                r_state <= S_DROP_RD;
                            end
                            REQ_CLOSE, REQ_REPORT: begin
                                r_dq    <= w_div_abs;
                                r_dsign <= w_div_src[SW-1];
                                r_ddiv  <= w_div_cnt;
                                r_drem  <= '0;
                                r_dcnt  <= DCW'(SW);
                                r_state <= S_DIV;
                            end
                            default: r_state <= S_SKIP;
                        endcase
                    end
                end
                S_DIV: begin
                    // one quotient bit a cycle
                    r_drem <= w_qbit ? FW'(w_shift - {1'b0, r_ddiv}) : FW'(w_shift);
                    r_dq   <= {r_dq[SW-2:0], w_qbit};
                    r_dcnt <= r_dcnt - DCW'(1);
                    if (r_dcnt == DCW'(1)) begin
                        r_state <= (r_kind == REQ_CLOSE) ? S_CLOSE : S_REPORT;
                    end
                end
                S_CLOSE: begin
                    r_v <= w_div_avg;
                    if (!store_valid(FW'(r_mfill), FW'(r_mokc))) begin
                        r_q <= Q_NOTVALID;
                    end else begin
                        r_q <= w_close_jump_ok ? Q_OK : Q_JUMP;
                    end
                    r_mfill <= '0;
                    r_mokc  <= '0;
                    r_msum  <= '0;
                    r_mhead <= '0;
                    r_mtail <= '0;
                    r_lvl   <= 1'b1;
                    r_state <= S_DROP_RD;
                end
                S_REPORT: begin
                    r_v     <= w_div_avg;
                    r_q     <= store_valid(FW'(r_pfill), FW'(r_pokc)) ? Q_OK : Q_NOTVALID;
                    r_pfill <= '0;
                    r_pokc  <= '0;
                    r_psum  <= '0;
                    r_phead <= '0;
                    r_ptail <= '0;
                    r_state <= S_DONE;
                end
                S_DROP_RD: begin
                    // head entry is read this cycle
                    r_state <= (w_cur_fill >= w_cur_cap) ? S_DROP : S_PUSH;
                end
                S_DROP: begin
                    // drop the oldest entry
                    if (r_lvl) begin
                        if (r_prd[DATA_W]) begin
                            r_pokc <= r_pokc - PFW'(1);
                            r_psum <= r_psum - PSW'($signed(r_prd[DATA_W-1:0]));
                        end
                        r_phead <= (r_phead == PAW'(PERIOD_SLOTS-1)) ? '0 : r_phead + PAW'(1);
                        r_pfill <= r_pfill - PFW'(1);
                    end else begin
                        if (r_mrd[DATA_W]) begin
                            r_mokc <= r_mokc - MFW'(1);
                            r_msum <= r_msum - MSW'($signed(r_mrd[DATA_W-1:0]));
                        end
                        r_mhead <= (r_mhead == MAW'(MINUTE_SLOTS-1)) ? '0 : r_mhead + MAW'(1);
                        r_mfill <= r_mfill - MFW'(1);
                    end
                    r_state <= S_DROP_RD;
                end
                S_PUSH: begin
                    if (r_lvl) begin
                        r_ptail <= (r_ptail == PAW'(PERIOD_SLOTS-1)) ? '0 : r_ptail + PAW'(1);
                        r_pfill <= r_pfill + PFW'(1);
                        if (r_q == Q_OK) begin
                            r_pokc  <= r_pokc + PFW'(1);
                            r_psum  <= r_psum + PSW'(r_v);
                            r_plast <= r_v;
                        end
                    end else begin
                        r_mtail <= (r_mtail == MAW'(MINUTE_SLOTS-1)) ? '0 : r_mtail + MAW'(1);
                        r_mfill <= r_mfill + MFW'(1);
                        if (r_q == Q_OK) begin
                            r_mokc  <= r_mokc + MFW'(1);
                            r_msum  <= r_msum + MSW'(r_v);
                            r_mlast <= r_v;
                        end
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= r_kind;
                        r_out_q     <= r_q;
                        r_out_avg   <= (r_kind == REQ_SAMPLE) ? '0 : r_v;
                        r_state     <= S_IDLE;
                    end
                end
                S_SKIP:  r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = {(TDATA_W-DATA_W-QUAL_W)'(0), r_out_avg, r_out_q};

endmodule

[rtl/ssqa_checker.sv]
// Port-level checker for the sensor sample quality aggregator, bound to the core.
// Depends on ssqa_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ssqa_checker
    import ssqa_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic [KIND_W-1:0]  m_axis_tuser
);

    logic              w_in_acc;
    logic              w_out_stall;
    logic              w_sample_out;
    logic              w_kind_known;
    logic [DATA_W-1:0] w_out_avg;
    logic [QUAL_W-1:0] w_out_q;

    assign w_in_acc     = s_axis_tvalid && s_axis_tready;
    assign w_out_stall  = m_axis_tvalid && !m_axis_tready;
    assign w_sample_out = m_axis_tvalid && (m_axis_tuser == REQ_SAMPLE);
    assign w_kind_known = m_axis_tuser inside {REQ_SAMPLE, REQ_CLOSE, REQ_REPORT};
    assign w_out_avg    = m_axis_tdata[DATA_W+QUAL_W-1:QUAL_W];
    assign w_out_q      = m_axis_tdata[QUAL_W-1:0];

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, m_axis_tvalid && $stable(m_axis_tdata))
    // one item at a time: ready drops after an accept
    `ASSERT_NEXT(a_one_item, i_clk, i_rst_n, w_in_acc, !s_axis_tready)
    // sample results carry a zero average
    `ASSERT_IMPL(a_sample_avg, i_clk, i_rst_n, w_sample_out, w_out_avg == '0)
    // sample results are never marked not valid, and no result has the unknown kind
    `ASSERT_IMPL(a_kind_qual, i_clk, i_rst_n, m_axis_tvalid, w_kind_known && !(w_sample_out && (w_out_q == Q_NOTVALID)))

endmodule

bind sensor_sample_quality_aggregator_core ssqa_checker u_ssqa_checker (.*);
